[rtl/core/hse_pkg.sv]
// shared types and constants for the heap sort engine
// command and status structs that join the controller and the datapath
package hse_pkg;

    localparam int VAL_W     = 32;
    localparam int DEPTH_DEF = 64;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_wr;
        logic start;
        logic build_rd;
        logic build_ld;
        logic sift_rd;
        logic sift_cmp;
        logic sift_fin;
        logic ext_rd;
        logic ext_wr;
        logic out_rd;
        logic out_ld;
    } t_cmd;

    // datapath status seen by the controller
    typedef struct packed {
        logic child_in;
        logic sift_cont;
        logic bi_zero;
        logic end_zero;
        logic out_free;
        logic out_last;
    } t_sts;

endpackage

[rtl/core/hse_ctrl.sv]
// sequencer for the heap sort engine: load, heap build, extraction, output
// depends on hse_pkg for the command and status structs
module hse_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    input  logic          i_s_axis_tlast,
    output logic          o_s_axis_tready,
    input  hse_pkg::t_sts i_sts,
    output hse_pkg::t_cmd o_cmd
);
    import hse_pkg::*;

    localparam logic [3:0] ST_LOAD     = 4'd0;
    localparam logic [3:0] ST_START    = 4'd1;
    localparam logic [3:0] ST_NEXT     = 4'd2;
    localparam logic [3:0] ST_BUILD_RD = 4'd3;
    localparam logic [3:0] ST_BUILD_LD = 4'd4;
    localparam logic [3:0] ST_SIFT_CHK = 4'd5;
    localparam logic [3:0] ST_SIFT_CMP = 4'd6;
    localparam logic [3:0] ST_EXT_RD   = 4'd7;
    localparam logic [3:0] ST_EXT_WR   = 4'd8;
    localparam logic [3:0] ST_OUT_RD   = 4'd9;
    localparam logic [3:0] ST_OUT_LD   = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_cmd.load_wr = 1'b1;
                    if (i_s_axis_tlast) begin
                        n_state = ST_START;
                    end
                end
            end
            ST_START: begin
                o_cmd.start = 1'b1;
                n_state     = ST_NEXT;
            end
            // build while heap nodes remain, then extract, then stream out
            ST_NEXT: begin
                if (!i_sts.bi_zero) begin
                    n_state = ST_BUILD_RD;
                end else if (i_sts.end_zero) begin
                    n_state = ST_OUT_RD;
                end else begin
                    n_state = ST_EXT_RD;
                end
            end
            ST_BUILD_RD: begin
                o_cmd.build_rd = 1'b1;
                n_state        = ST_BUILD_LD;
            end
            ST_BUILD_LD: begin
                o_cmd.build_ld = 1'b1;
                n_state        = ST_SIFT_CHK;
            end
            ST_SIFT_CHK: begin
                if (i_sts.child_in) begin
                    o_cmd.sift_rd = 1'b1;
                    n_state       = ST_SIFT_CMP;
                end else begin
                    o_cmd.sift_fin = 1'b1;
                    n_state        = ST_NEXT;
                end
            end
            ST_SIFT_CMP: begin
                o_cmd.sift_cmp = 1'b1;
                n_state        = i_sts.sift_cont ? ST_SIFT_CHK : ST_NEXT;
            end
            ST_EXT_RD: begin
                o_cmd.ext_rd = 1'b1;
                n_state      = ST_EXT_WR;
            end
            ST_EXT_WR: begin
                o_cmd.ext_wr = 1'b1;
                n_state      = ST_SIFT_CHK;
            end
            ST_OUT_RD: begin
                o_cmd.out_rd = 1'b1;
                n_state      = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = i_sts.out_last ? ST_LOAD : ST_OUT_RD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

endmodule

[rtl/core/hse_dp.sv]
// datapath of the heap sort engine: element memory, sift registers, output register
// depends on hse_pkg; driven by hse_ctrl through t_cmd, reports through t_sts
module hse_dp #(
    parameter int DEPTH = hse_pkg::DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  hse_pkg::t_cmd             i_cmd,
    output hse_pkg::t_sts             o_sts,
    input  logic [hse_pkg::VAL_W-1:0] i_value,
    input  logic                      i_m_axis_tready,
    output logic                      o_m_axis_tvalid,
    output logic [hse_pkg::VAL_W-1:0] o_m_axis_tdata,
    output logic                      o_m_axis_tlast,
    output logic                      o_m_axis_tuser
);
    import hse_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [VAL_W-1:0] r_mem [DEPTH];

    logic [CW-1:0]    r_count;
    logic             r_ovf;
    logic [AW-1:0]    r_bi;
    logic [AW-1:0]    r_node;
    logic [AW-1:0]    r_end;
    logic [AW-1:0]    r_k;
    logic [VAL_W-1:0] r_v;
    logic [VAL_W-1:0] r_rd0;
    logic [VAL_W-1:0] r_rd1;
    logic             r_out_valid;
    logic [VAL_W-1:0] r_out_val;
    logic             r_out_last;
    logic             r_out_drop;

    logic [AW:0]      w_child;
    logic             w_child_in;
    logic             w_has_right;
    logic             w_pick_r;
    logic [VAL_W-1:0] w_big;
    logic             w_cont;
    logic [AW-1:0]    w_next_node;
    logic             w_k_last;
    logic             w_out_free;
    logic             w_room;

    logic             w_we;
    logic [AW-1:0]    w_wa;
    logic [VAL_W-1:0] w_wd;
    logic             w_re;
    logic [AW-1:0]    w_ra0;
    logic [AW-1:0]    w_ra1;

    assign w_child     = {r_node, 1'b1};
    assign w_child_in  = w_child <= {1'b0, r_end};
    assign w_has_right = w_child < {1'b0, r_end};
    assign w_pick_r    = w_has_right && ($signed(r_rd0) < $signed(r_rd1));
    assign w_big       = w_pick_r ? r_rd1 : r_rd0;
    assign w_cont      = $signed(r_v) < $signed(w_big);
    assign w_next_node = w_child[AW-1:0] + AW'(w_pick_r);
    assign w_k_last    = (CW'(r_k) + CW'(1)) == r_count;
    assign w_out_free  = !r_out_valid || i_m_axis_tready;
    assign w_room      = r_count < DEPTH_C;

    assign o_sts.child_in  = w_child_in;
    assign o_sts.sift_cont = w_cont;
    assign o_sts.bi_zero   = r_bi == '0;
    assign o_sts.end_zero  = r_end == '0;
    assign o_sts.out_free  = w_out_free;
    assign o_sts.out_last  = w_k_last;

    // read port addresses
    always_comb begin
        w_re  = i_cmd.build_rd | i_cmd.sift_rd | i_cmd.ext_rd | i_cmd.out_rd;
        w_ra0 = r_k;
        w_ra1 = r_end;
        if (i_cmd.build_rd) begin
            w_ra0 = r_bi - AW'(1);
        end else if (i_cmd.sift_rd) begin
            w_ra0 = w_child[AW-1:0];
            w_ra1 = w_child[AW-1:0] + AW'(1);
        end else if (i_cmd.ext_rd) begin
            w_ra0 = '0;
        end
    end

    // write port: store, sift hole fill, or root moved to the heap end
    always_comb begin
        w_we = 1'b0;
        w_wa = r_node;
        w_wd = r_v;
        if (i_cmd.load_wr) begin
            w_we = w_room;
            w_wa = r_count[AW-1:0];
            w_wd = i_value;
        end else if (i_cmd.sift_cmp) begin
            w_we = 1'b1;
            w_wd = w_cont ? w_big : r_v;
        end else if (i_cmd.sift_fin) begin
            w_we = 1'b1;
        end else if (i_cmd.ext_wr) begin
            w_we = 1'b1;
            w_wa = r_end;
            w_wd = r_rd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_rd0 <= r_mem[w_ra0];
            r_rd1 <= r_mem[w_ra1];
        end
    end

    // batch control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_wr) begin
                if (w_room) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.out_ld && w_k_last) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
            if (i_cmd.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // sort indices and held values
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_bi  <= AW'(r_count >> 1);
            r_end <= AW'(r_count - CW'(1));
            r_k   <= '0;
        end
        if (i_cmd.build_rd) begin
            r_bi   <= r_bi - AW'(1);
            r_node <= r_bi - AW'(1);
        end
        if (i_cmd.build_ld) begin
            r_v <= r_rd0;
        end
        if (i_cmd.sift_cmp && w_cont) begin
            r_node <= w_next_node;
        end
        if (i_cmd.ext_wr) begin
            r_v    <= r_rd1;
            r_node <= '0;
            r_end  <= r_end - AW'(1);
        end
        if (i_cmd.out_ld) begin
            r_k        <= r_k + AW'(1);
            r_out_val  <= r_rd0;
            r_out_last <= w_k_last;
            r_out_drop <= r_ovf;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_val;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_drop;

endmodule

[rtl/core/heap_sort_engine_core.sv]
// Batch heap sorter. Signed 32-bit values stream in, one per cycle, and are
// stored until a beat with tlast arrives (that beat belongs to the batch);
// beats past DEPTH entries are discarded and every result of that batch then
// carries tuser = 1. The batch is turned into a max-heap and extracted in
// place in a single memory with two read ports and one write port, then
// streamed out smallest first with tlast on the final result. The input takes
// no beats from the tlast beat until the last result is loaded into the output
// register. Each heap level of a sift reads the children, then compares and
// writes; each result is read from memory and then loaded into the output
// register once that register is free.
// depends on hse_pkg, hse_ctrl and hse_dp
module heap_sort_engine_core #(
    parameter int DEPTH = hse_pkg::DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [hse_pkg::VAL_W-1:0] i_s_axis_tdata,  // [31:0] value
    input  logic                      i_s_axis_tlast,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [hse_pkg::VAL_W-1:0] o_m_axis_tdata,  // [31:0] sorted_value
    output logic                      o_m_axis_tlast,
    output logic                      o_m_axis_tuser   // [0] dropped
);
    import hse_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    hse_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (w_sts),
        .o_cmd           (w_cmd)
    );

    hse_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_value         (i_s_axis_tdata),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule
